>>> design/ipv4_dotted_address_parser_defines.svh
// Assertion macros for the IPv4 dotted-address parser.
// Included by the top level; no other dependencies.
`ifndef IPV4_DOTTED_ADDRESS_PARSER_DEFINES_SVH
`define IPV4_DOTTED_ADDRESS_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IPDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define IPDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ipda_pkg.sv
// Types, character codes and parse-step functions for the IPv4 address parser.
// No dependencies.
package ipda_pkg;

  localparam int AccWidth = 64;

  typedef enum logic [2:0] {
    PhLead,
    PhSign,
    PhZero,
    PhHexp,
    PhDigs
  } phase_e;

  typedef enum logic [1:0] {
    BaseDec,
    BaseOct,
    BaseHex
  } base_e;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharOne   = 8'h31;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [7:0] CharUpX   = 8'h58;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharLowX  = 8'h78;

  localparam logic [4:0] DigNone  = 5'd16;
  localparam logic [4:0] RadixDec = 5'd10;
  localparam logic [4:0] RadixOct = 5'd8;
  localparam logic [4:0] RadixHex = 5'd16;

  localparam logic [1:0] MaxParts = 2'd3;

  localparam logic [31:0] Limit24 = 32'h00ff_ffff;
  localparam logic [31:0] Limit16 = 32'h0000_ffff;
  localparam logic [31:0] Limit8  = 32'h0000_00ff;

  typedef struct packed {
    phase_e                phase;
    base_e                 base;
    logic [AccWidth-1:0]   acc;
    logic                  ovf;
    logic                  neg;
    logic [1:0]            cnt;
    logic [2:0][7:0]       parts;
    logic                  too_big;
    logic                  finished;
    logic                  failed;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic        addr_valid;
    logic [31:0] address;
  } result_t;

  typedef struct packed {
    logic res_load;
    logic at_rest;
  } core_status_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic [4:0] digit_value(logic [7:0] c);
    logic [4:0] d;
    if ((c >= CharZero) && (c <= CharNine)) begin
      d = 5'(c - CharZero);
    end else if ((c >= CharLowA) && (c <= CharLowF)) begin
      d = 5'(c - CharLowA) + 5'd10;
    end else if ((c >= CharUpA) && (c <= CharUpF)) begin
      d = 5'(c - CharUpA) + 5'd10;
    end else begin
      d = DigNone;
    end
    return d;
  endfunction

  function automatic logic [4:0] radix_of(base_e b);
    logic [4:0] r;
    unique case (b)
      BaseOct: r = RadixOct;
      BaseHex: r = RadixHex;
      default: r = RadixDec;
    endcase
    return r;
  endfunction

  function automatic parse_state_t start_number(parse_state_t s);
    parse_state_t n;
    n       = s;
    n.phase = PhLead;
    n.base  = BaseDec;
    n.acc   = '0;
    n.ovf   = 1'b0;
    n.neg   = 1'b0;
    return n;
  endfunction

  function automatic parse_state_t reset_state();
    parse_state_t n;
    n          = '0;
    n.phase    = PhLead;
    n.base     = BaseDec;
    return n;
  endfunction

  // acc * radix + d, four extra bits to catch overflow
  function automatic logic [AccWidth+3:0] mac(logic [AccWidth-1:0] acc, base_e b,
                                              logic [3:0] d);
    logic [AccWidth+3:0] a_w;
    logic [AccWidth+3:0] prod;
    a_w = {4'b0, acc};
    unique case (b)
      BaseOct: prod = a_w << 3;
      BaseHex: prod = a_w << 4;
      default: prod = (a_w << 3) + (a_w << 1);
    endcase
    return prod + {{AccWidth{1'b0}}, d};
  endfunction

  // signed part value above 0xff, judged on the full accumulator
  function automatic logic part_big(logic [AccWidth-1:0] acc, logic neg);
    logic big;
    if (!neg) begin
      big = |acc[AccWidth-1:8];
    end else begin
      big = !((acc == '0) || ((&acc[AccWidth-1:8]) && (|acc[7:0])));
    end
    return big;
  endfunction

  function automatic parse_state_t end_number(parse_state_t s, logic [7:0] c);
    parse_state_t n;
    logic [7:0]   low;
    n   = s;
    low = s.neg ? 8'(8'h00 - s.acc[7:0]) : s.acc[7:0];
    if (s.ovf) begin
      n.failed = 1'b1;
    end else if (c == CharDot) begin
      if (s.cnt == MaxParts) begin
        n.failed = 1'b1;
      end else begin
        n.too_big       = s.too_big | part_big(s.acc, s.neg);
        n.parts[s.cnt]  = low;
        n.cnt           = s.cnt + 2'd1;
        n               = start_number(n);
      end
    end else if ((c == CharNul) || is_space(c)) begin
      n.finished = 1'b1;
    end else begin
      n.failed = 1'b1;
    end
    return n;
  endfunction

  function automatic parse_state_t take_char(parse_state_t s, logic [7:0] c);
    parse_state_t        n;
    logic [4:0]          d;
    logic [AccWidth+3:0] sum;
    logic                lead;
    n    = s;
    d    = digit_value(c);
    sum  = mac(s.acc, s.base, d[3:0]);
    lead = (s.phase == PhLead);
    unique case (s.phase)
      PhLead, PhSign: begin
        if (lead && is_space(c)) begin
          n = s;
        end else if (lead && (c == CharPlus)) begin
          n.phase = PhSign;
        end else if (lead && (c == CharMinus)) begin
          n.neg   = 1'b1;
          n.phase = PhSign;
        end else if (c == CharZero) begin
          n.acc   = '0;
          n.phase = PhZero;
        end else if ((c >= CharOne) && (c <= CharNine)) begin
          n.base  = BaseDec;
          n.acc   = AccWidth'(d[3:0]);
          n.phase = PhDigs;
        end else begin
          n.failed = 1'b1;
        end
      end
      PhZero: begin
        if ((c == CharLowX) || (c == CharUpX)) begin
          n.phase = PhHexp;
        end else if ((c >= CharZero) && (c <= CharSeven)) begin
          n.base  = BaseOct;
          n.acc   = AccWidth'(d[3:0]);
          n.phase = PhDigs;
        end else begin
          n = end_number(s, c);
        end
      end
      PhHexp: begin
        if (d != DigNone) begin
          n.base  = BaseHex;
          n.acc   = AccWidth'(d[3:0]);
          n.phase = PhDigs;
        end else begin
          n.failed = 1'b1;
        end
      end
      default: begin
        if (d < radix_of(s.base)) begin
          n.ovf = s.ovf | (|sum[AccWidth+3:AccWidth]);
          n.acc = sum[AccWidth-1:0];
        end else begin
          n = end_number(s, c);
        end
      end
    endcase
    return n;
  endfunction

  function automatic parse_state_t step(parse_state_t s, logic [7:0] c);
    parse_state_t n;
    if (s.finished || s.failed) begin
      n = s;
    end else begin
      n = take_char(s, c);
    end
    return n;
  endfunction

  function automatic result_t verdict(parse_state_t s);
    result_t     r;
    logic        ok;
    logic [31:0] v32;
    logic [31:0] val;
    ok  = s.finished && !s.failed && !s.too_big;
    v32 = s.neg ? (32'h0 - s.acc[31:0]) : s.acc[31:0];
    val = v32;
    unique case (s.cnt)
      2'd1: begin
        if (v32 > Limit24) ok = 1'b0;
        val = v32 | {s.parts[0], 24'h0};
      end
      2'd2: begin
        if (v32 > Limit16) ok = 1'b0;
        val = v32 | {s.parts[0], s.parts[1], 16'h0};
      end
      2'd3: begin
        if (v32 > Limit8) ok = 1'b0;
        val = v32 | {s.parts[0], s.parts[1], s.parts[2], 8'h0};
      end
      default: val = v32;
    endcase
    r.addr_valid = ok;
    r.address    = ok ? val : 32'h0;
    return r;
  endfunction

endpackage

>>> design/ipda_in_stage.sv
// Input register for the IPv4 address parser: holds one beat until the core takes it.
// Depends on ipda_pkg.
module ipda_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    char_code_i,
  input  logic          last_char_i,
  input  logic          consume_i,
  output logic          item_valid_o,
  output ipda_pkg::item_t item_o
);
  import ipda_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = valid_q && !consume_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= '{char_code: char_code_i, last_char: last_char_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> design/ipda_parse_core.sv
// Parse state register, per-character step logic and result register.
// Depends on ipda_pkg.
module ipda_parse_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  ipda_pkg::item_t        item_i,
  output logic                   consume_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output ipda_pkg::result_t      result_o,
  output ipda_pkg::core_status_t status_o
);
  import ipda_pkg::*;

  parse_state_t state_q, state_d;
  parse_state_t after_char;
  parse_state_t after_end;
  result_t      result_q;
  logic         out_valid_q, out_valid_d;
  logic         advance;
  logic         res_load;

  assign advance   = !out_valid_q || !out_stall_i;
  assign consume_o = item_valid_i && (!item_i.last_char || advance);
  assign res_load  = consume_o && item_i.last_char;

  // on the last beat an implied NUL closes the string
  always_comb begin
    after_char = step(state_q, item_i.char_code);
    after_end  = step(after_char, CharNul);
  end

  always_comb begin
    state_d = state_q;
    if (res_load) begin
      state_d = reset_state();
    end else if (consume_o) begin
      state_d = after_char;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= reset_state();
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      result_q <= verdict(after_end);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_o          = result_q;
  assign status_o.res_load = res_load;
  assign status_o.at_rest  = (state_q.phase == PhLead) && (state_q.cnt == 2'd0) &&
                             !state_q.finished && !state_q.failed;

endmodule

>>> design/ipv4_dotted_address_parser.sv
// Top level of the IPv4 dotted-address parser: input register, parse core, assertions.
// Depends on ipda_pkg, ipda_in_stage, ipda_parse_core and the defines header.
//
// Usage:
//   Input channel: one string byte per beat on char_code_i, with last_char_i set
//   on the final byte. A beat is taken when in_valid_i is high and in_stall_o low.
//   Output channel: one beat per string, given for the byte marked last:
//   addr_valid_o and address_o (first part in bits 31:24, zero when invalid).
//   A beat is taken when out_valid_o is high and out_stall_i low.
//   Throughput: one byte per cycle, sustained, with no gaps between strings, while
//   out_stall_i does not hold back a waiting result. Path: a last byte taken into
//   the input register passes the combinational step logic (a 68-bit
//   multiply-by-radix add) into the result register, from which its beat is offered.
//   Stall: a waiting result holds in the result register; non-last bytes keep
//   flowing, and the next last byte waits in the input register, after which
//   in_stall_o rises until the result is taken.
//   Reset: asynchronous and active low; clears all parse state and drops both
//   valids. The parse restarts after every result.
module ipv4_dotted_address_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        addr_valid_o,
  output logic [31:0] address_o
);
  import ipda_pkg::*;

  `include "ipv4_dotted_address_parser_defines.svh"

  logic         item_valid;
  item_t        item;
  logic         consume;
  result_t      result;
  core_status_t status;

  ipda_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .last_char_i  (last_char_i),
    .consume_i    (consume),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ipda_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .consume_o    (consume),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result),
    .status_o     (status)
  );

  assign addr_valid_o = result.addr_valid;
  assign address_o    = result.address;

  `IPDA_ASSERT_IMPLY(a_invalid_zero, clk_i, rst_ni, out_valid_o && !addr_valid_o,
                     address_o == 32'h0, "address not zero on failed parse")
  `IPDA_ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, in_stall_o,
                     item_valid && out_valid_o && out_stall_i,
                     "input stalled without a blocked result")
  `IPDA_ASSERT_NEXT(a_restart, clk_i, rst_ni, status.res_load,
                    status.at_rest && out_valid_o, "parse state not cleared after result")

endmodule

>>> verif/ipv4_dotted_address_parser_tb.sv
// Testbench for ipv4_dotted_address_parser: feeds address strings one byte per beat
// and checks each verdict and address word against an in-bench parser model.
// Depends on ipda_pkg and the design top level.
module ipv4_dotted_address_parser_tb;
  import ipda_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int RandomChars = 560;
  localparam int StreamChars = 200;
  localparam logic [63:0] AllOnes = '1;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
  } addr_verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = '0;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        addr_valid_o;
  logic [31:0] address_o;

  bit            idle_on = 1'b0;
  int            err_count = 0;
  int            chars_sent = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;
  addr_verdict_t verdict_q[$];

  phase_e      pr_phase = PhLead;
  base_e       pr_base = BaseDec;
  logic [63:0] pr_acc = '0;
  bit          pr_ovf = 1'b0;
  bit          pr_neg = 1'b0;
  int          pr_cnt = 0;
  logic [7:0]  pr_parts[3] = '{default: '0};
  bit          pr_big = 1'b0;
  bit          pr_done = 1'b0;
  bit          pr_bad = 1'b0;

  ipv4_dotted_address_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .addr_valid_o(addr_valid_o),
    .address_o   (address_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit blank_char(logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

  function automatic logic [4:0] digit_of(logic [7:0] c);
    if ((c >= CharZero) && (c <= CharNine)) return 5'(c - CharZero);
    if ((c >= CharLowA) && (c <= CharLowF)) return 5'(c - CharLowA) + 5'd10;
    if ((c >= CharUpA) && (c <= CharUpF)) return 5'(c - CharUpA) + 5'd10;
    return DigNone;
  endfunction

  function automatic logic [4:0] radix_now();
    case (pr_base)
      BaseOct: return RadixOct;
      BaseHex: return RadixHex;
      default: return RadixDec;
    endcase
  endfunction

  function automatic void open_number();
    pr_phase = PhLead;
    pr_base  = BaseDec;
    pr_acc   = '0;
    pr_ovf   = 1'b0;
    pr_neg   = 1'b0;
  endfunction

  function automatic void clear_parse();
    open_number();
    pr_cnt   = 0;
    pr_parts = '{default: '0};
    pr_big   = 1'b0;
    pr_done  = 1'b0;
    pr_bad   = 1'b0;
  endfunction

  function automatic void close_number(logic [7:0] c);
    logic [63:0] v;
    if (pr_ovf) begin
      pr_bad = 1'b1;
      return;
    end
    v = pr_neg ? (64'd0 - pr_acc) : pr_acc;
    if (c == CharDot) begin
      if (pr_cnt >= MaxParts) begin
        pr_bad = 1'b1;
      end else begin
        if (v > Limit8) pr_big = 1'b1;
        pr_parts[pr_cnt] = v[7:0];
        pr_cnt++;
        open_number();
      end
    end else if ((c == CharNul) || blank_char(c)) begin
      pr_acc  = v;
      pr_done = 1'b1;
    end else begin
      pr_bad = 1'b1;
    end
  endfunction

  function automatic void feed_char(logic [7:0] c);
    logic [63:0] d;
    logic [63:0] r;
    d = 64'(digit_of(c));
    r = 64'(radix_now());
    case (pr_phase)
      PhLead, PhSign: begin
        if (!((pr_phase == PhLead) && blank_char(c))) begin
          if ((pr_phase == PhLead) && (c == CharPlus)) begin
            pr_phase = PhSign;
          end else if ((pr_phase == PhLead) && (c == CharMinus)) begin
            pr_neg   = 1'b1;
            pr_phase = PhSign;
          end else if (c == CharZero) begin
            pr_acc   = '0;
            pr_phase = PhZero;
          end else if ((c >= CharOne) && (c <= CharNine)) begin
            pr_base  = BaseDec;
            pr_acc   = d;
            pr_phase = PhDigs;
          end else begin
            pr_bad = 1'b1;
          end
        end
      end
      PhZero: begin
        if ((c == CharLowX) || (c == CharUpX)) begin
          pr_phase = PhHexp;
        end else if ((c >= CharZero) && (c <= CharSeven)) begin
          pr_base  = BaseOct;
          pr_acc   = d;
          pr_phase = PhDigs;
        end else begin
          close_number(c);
        end
      end
      PhHexp: begin
        if (d < 64'(RadixHex)) begin
          pr_base  = BaseHex;
          pr_acc   = d;
          pr_phase = PhDigs;
        end else begin
          pr_bad = 1'b1;
        end
      end
      default: begin
        if (d < r) begin
          if (pr_acc > (AllOnes - d) / r) pr_ovf = 1'b1;
          pr_acc = pr_acc * r + d;
        end else begin
          close_number(c);
        end
      end
    endcase
  endfunction

  // returns 1 when the byte closes a string and yields a verdict
  function automatic bit predict_item(logic [7:0] c, bit last, output addr_verdict_t r);
    logic [31:0] val;
    bit          ok;
    r = '0;
    if (!pr_done && !pr_bad) feed_char(c);
    if (!last) return 1'b0;
    if (!pr_done && !pr_bad) feed_char(CharNul);
    ok  = pr_done && !pr_bad && !((pr_cnt >= 1) && pr_big);
    val = pr_acc[31:0];
    if (ok) begin
      case (pr_cnt)
        1: begin
          if (val > Limit24) ok = 1'b0;
          else val |= {pr_parts[0], 24'h0};
        end
        2: begin
          if (val > Limit16) ok = 1'b0;
          else val |= {pr_parts[0], pr_parts[1], 16'h0};
        end
        3: begin
          if (val > Limit8) ok = 1'b0;
          else val |= {pr_parts[0], pr_parts[1], pr_parts[2], 8'h0};
        end
        default: ;
      endcase
    end
    r.ok   = ok;
    r.addr = ok ? val : '0;
    clear_parse();
    return 1'b1;
  endfunction

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? CharSpace : 8'($urandom_range(CharTab, CharCr));
  endfunction

  // random radix, random prefix and letter case
  function automatic byte_q_t number_text(logic [63:0] v);
    string      s;
    byte_q_t    q;
    logic [7:0] c;
    case ($urandom_range(0, 2))
      0: s = $sformatf("%0d", v);
      1: s = $sformatf("0%0o", v);
      default: s = $sformatf("%s%0h", $urandom_range(0, 1) ? "0x" : "0X", v);
    endcase
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if ((c >= CharLowA) && (c <= CharLowF) && ($urandom_range(0, 1) != 0)) begin
        c = c - (CharLowA - CharUpA);
      end
      q.push_back(c);
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
    err_count++;
  endtask

  task automatic send_char(logic [7:0] c, bit last);
    addr_verdict_t want;
    if (idle_on && ($urandom_range(0, 5) == 0)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    chars_sent++;
    if (predict_item(c, last, want)) verdict_q.push_back(want);
  endtask

  task automatic send_seq(byte_q_t seq);
    for (int i = 0; i < seq.size(); i++) send_char(seq[i], i == seq.size() - 1);
  endtask

  task automatic send_text(string s);
    send_seq(text_bytes(s));
  endtask

  task automatic send_random_address();
    byte_q_t     seq;
    int          n_parts;
    int          pick;
    logic [63:0] v;
    logic [63:0] lim;
    n_parts = $urandom_range(1, 4);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) seq.push_back(pick_blank());
    end
    for (int i = 0; i < n_parts; i++) begin
      if (i != 0) seq.push_back(CharDot);
      pick = $urandom_range(0, 19);
      if (pick == 0) seq.push_back(CharMinus);
      else if (pick == 1) seq.push_back(CharPlus);
      if (i < n_parts - 1) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) v = $urandom_range(256, 70000);
        else if (pick == 1) v = Limit8;
        else v = $urandom_range(0, 255);
        seq = {seq, number_text(v)};
      end else begin
        case (n_parts)
          1: lim = 64'hffff_ffff;
          2: lim = Limit24;
          3: lim = Limit16;
          default: lim = Limit8;
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
          0: v = lim;
          1: v = lim + 64'd1;
          2, 3: v = {$urandom, $urandom};
          default: v = $urandom_range(0, lim[31:0]);
        endcase
        seq = {seq, number_text(v)};
        if (pick == 3) seq.push_back(CharZero + 8'($urandom_range(0, 7)));
      end
    end
    pick = $urandom_range(0, 3);
    if (pick >= 2) begin
      seq.push_back((pick == 2) ? CharNul : pick_blank());
      repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      pick = $urandom_range(0, seq.size() - 1);
      case ($urandom_range(0, 2))
        0: seq[pick] = 8'($urandom_range(0, 255));
        1: seq[pick] = CharDot;
        default: if (seq.size() > 1) seq.delete(pick);
      endcase
    end
    send_seq(seq);
  endtask

  task automatic send_noise();
    string   alpha;
    byte_q_t seq;
    alpha = "0123456789abcdefABCDEFxX.+- \t";
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 1) != 0) seq.push_back(8'($urandom_range(0, 255)));
      else seq.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
    end
    send_seq(seq);
  endtask

  task automatic test_valid_forms();
    byte_q_t seq;
    send_text("0.0.0.0");
    send_text("255.255.255.255");
    send_text("4294967295");
    send_text("0xFFFFFFFF");
    send_text("0377.0xff.255.0");
    send_text("0XaB.0x0.0377.9");
    send_text("1.16777215");
    send_text("1.2.65535");
    send_text("-1");
    send_text("+10.0.0.1");
    send_text(" \t10.1");
    send_text("1.-0.3");
    send_text("1.2.3.4 junk");
    seq = text_bytes("1.2.3.4");
    seq.push_back(CharNul);
    seq = {seq, text_bytes("zz")};
    send_seq(seq);
  endtask

  task automatic test_malformed();
    byte_q_t seq;
    seq = {CharNul};
    send_seq(seq);
    send_text("-");
    send_text(".1");
    send_text("1..2");
    send_text("0x");
    send_text("0x.1");
    send_text("09");
    send_text("18446744073709551615");
    send_text("18446744073709551616");
    send_text("0x10000000000000000");
    send_text("1.2.3.4.5");
    send_text("256.1");
    send_text("-1.2");
    send_text("1.16777216");
    send_text("1.2.65536");
    send_text("1.2.3.256");
    send_text("1.2.3.a");
  endtask

  task automatic test_random_addresses(int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_random_address();
    end
  endtask

  task automatic test_streaming(int n_chars);
    int stop_at;
    stop_at = chars_sent + n_chars;
    idle_on = 1'b0;
    while (chars_sent < stop_at) send_random_address();
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && ($urandom_range(0, 7) == 0)) begin
      stall_left  <= $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    addr_verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("result beat with none expected", address_o, '0);
      end else begin
        want = verdict_q.pop_front();
        if (addr_valid_o !== want.ok) begin
          report_mismatch("addr_valid", 32'(addr_valid_o), 32'(want.ok));
        end
        if (address_o !== want.addr) report_mismatch("address", address_o, want.addr);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    test_valid_forms();
    test_malformed();
    test_random_addresses(RandomChars);
    test_streaming(StreamChars);
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
